>>> rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants for the binary content sniffer.
// ----------------------------------------------------------------------------
package bcs_pkg;

   localparam int SAMPLE_MAX_DEF = 512;
   localparam int PCT_W          = 7;
   localparam int FIELD_W        = 10;
   localparam int CENT           = 100;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NULL_PCT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NONPRINT_PCT = 1'b1;

   localparam logic [PCT_W-1:0] NULL_PCT_RST     = 7'd1;
   localparam logic [PCT_W-1:0] NONPRINT_PCT_RST = 7'd30;

   // byte classes
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // signatures, first byte in the top bits
   localparam logic [15:0] SIG_GZIP   = 16'h1F8B;
   localparam logic [31:0] SIG_ZIP_A  = 32'h504B0304;
   localparam logic [31:0] SIG_ZIP_B  = 32'h504B0506;
   localparam logic [31:0] SIG_PNG    = 32'h89504E47;
   localparam logic [23:0] SIG_JPEG   = 24'hFFD8FF;
   localparam logic [31:0] SIG_GIF    = 32'h47494638;
   localparam logic [31:0] SIG_PDF    = 32'h25504446;
   localparam logic [31:0] SIG_ELF    = 32'h7F454C46;
   localparam logic [15:0] SIG_MZ     = 16'h4D5A;
   localparam logic [31:0] SIG_MACHO  = 32'hCAFEBABE;
   localparam logic [31:0] SIG_WOFF_A = 32'h774F4646;
   localparam logic [31:0] SIG_WOFF_B = 32'h774F4632;

   // verdict codes
   localparam logic [3:0] V_TEXT     = 4'd0;
   localparam logic [3:0] V_GZIP     = 4'd1;
   localparam logic [3:0] V_ZIP      = 4'd2;
   localparam logic [3:0] V_PNG      = 4'd3;
   localparam logic [3:0] V_JPEG     = 4'd4;
   localparam logic [3:0] V_GIF      = 4'd5;
   localparam logic [3:0] V_PDF      = 4'd6;
   localparam logic [3:0] V_ELF      = 4'd7;
   localparam logic [3:0] V_MZ       = 4'd8;
   localparam logic [3:0] V_MACHO    = 4'd9;
   localparam logic [3:0] V_WOFF     = 4'd10;
   localparam logic [3:0] V_NULLS    = 4'd11;
   localparam logic [3:0] V_CONTROLS = 4'd12;
   localparam logic [3:0] V_EMPTY    = 4'd13;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } bcs_req_type;

   typedef struct packed {
      logic               binary_flag;
      logic [3:0]         verdict;
      logic [FIELD_W-1:0] sample_length;
      logic [FIELD_W-1:0] zero_total;
      logic [FIELD_W-1:0] control_total;
   } bcs_rsp_type;

endpackage

>>> rtl/bcs_accum.sv
// ----------------------------------------------------------------------------
// bcs_accum
// Input register, per-word counting and the end-of-content snapshot.
// ----------------------------------------------------------------------------
module bcs_accum #(
   parameter int SAMPLE_MAX = bcs_pkg::SAMPLE_MAX_DEF,
   parameter int CNT_W      = $clog2(SAMPLE_MAX + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bcs_pkg::bcs_req_type req_data,
   output logic                snap_valid,
   input  logic                snap_ready,
   output logic [3:0][7:0]     snap_prefix,
   output logic [CNT_W-1:0]    snap_count,
   output logic [CNT_W-1:0]    snap_zeros,
   output logic [CNT_W-1:0]    snap_ctrls
);
   import bcs_pkg::*;

   bcs_req_type        in_ff;
   logic               in_v_ff;
   logic [3:0][7:0]    prefix_ff, prefix_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   zeros_ff, zeros_in;
   logic [CNT_W-1:0]   ctrls_ff, ctrls_in;
   logic               snap_v_ff;
   logic [3:0][7:0]    snap_prefix_ff;
   logic [CNT_W-1:0]   snap_count_ff, snap_zeros_ff, snap_ctrls_ff;
   logic               take, is_nul, is_ctrl, in_move;

   assign in_move   = in_v_ff && (!in_ff.last || !snap_v_ff || snap_ready);
   assign req_ready = !in_v_ff || in_move;

   assign take    = in_v_ff && in_ff.has_byte && (count_ff < CNT_W'(SAMPLE_MAX));
   assign is_nul  = (in_ff.data_byte == BYTE_NUL);
   assign is_ctrl = (in_ff.data_byte < CTRL_LIMIT) && (in_ff.data_byte != BYTE_TAB) &&
                    (in_ff.data_byte != BYTE_LF) && (in_ff.data_byte != BYTE_CR);

   always_comb begin
      count_in = take ? count_ff + CNT_W'(1) : count_ff;
      zeros_in = (take && is_nul) ? zeros_ff + CNT_W'(1) : zeros_ff;
      ctrls_in = (take && is_ctrl) ? ctrls_ff + CNT_W'(1) : ctrls_ff;
      for (int i = 0; i < 4; i++) begin
         prefix_in[i] = (take && count_ff == CNT_W'(i)) ? in_ff.data_byte : prefix_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         snap_v_ff <= 1'b0;
         prefix_ff <= '0;
         count_ff  <= '0;
         zeros_ff  <= '0;
         ctrls_ff  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_v_ff <= 1'b1;
         end else if (in_move) begin
            in_v_ff <= 1'b0;
         end
         if (in_move && in_ff.last) begin
            snap_v_ff <= 1'b1;
            prefix_ff <= '0;
            count_ff  <= '0;
            zeros_ff  <= '0;
            ctrls_ff  <= '0;
         end else begin
            if (snap_ready) begin
               snap_v_ff <= 1'b0;
            end
            if (in_move) begin
               prefix_ff <= prefix_in;
               count_ff  <= count_in;
               zeros_ff  <= zeros_in;
               ctrls_ff  <= ctrls_in;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (in_move && in_ff.last) begin
         snap_prefix_ff <= prefix_in;
         snap_count_ff  <= count_in;
         snap_zeros_ff  <= zeros_in;
         snap_ctrls_ff  <= ctrls_in;
      end
   end

   assign snap_valid  = snap_v_ff;
   assign snap_prefix = snap_prefix_ff;
   assign snap_count  = snap_count_ff;
   assign snap_zeros  = snap_zeros_ff;
   assign snap_ctrls  = snap_ctrls_ff;

endmodule

>>> rtl/bcs_judge.sv
// ----------------------------------------------------------------------------
// bcs_judge
// Signature match, threshold tests and the result register.
// ----------------------------------------------------------------------------
module bcs_judge #(
   parameter int CNT_W = $clog2(bcs_pkg::SAMPLE_MAX_DEF + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       snap_valid,
   output logic                       snap_ready,
   input  logic [3:0][7:0]            snap_prefix,
   input  logic [CNT_W-1:0]           snap_count,
   input  logic [CNT_W-1:0]           snap_zeros,
   input  logic [CNT_W-1:0]           snap_ctrls,
   input  logic [bcs_pkg::PCT_W-1:0]  null_pct,
   input  logic [bcs_pkg::PCT_W-1:0]  nonprint_pct,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bcs_pkg::bcs_rsp_type       rsp_data
);
   import bcs_pkg::*;

   localparam int PW = CNT_W + PCT_W;
   localparam int WIDE_W = 16;

   logic [31:0]        head;
   logic [PW-1:0]      null_lim, ctrl_lim, zero_scaled, ctrl_scaled;
   logic               n2, n3, n4;
   logic [3:0]         verdict;
   logic [WIDE_W-1:0]  len_w, zero_w, ctrl_w;
   bcs_rsp_type        rsp_ff, rsp_in;
   logic               rsp_v_ff;

   assign snap_ready = !rsp_v_ff || rsp_ready;

   assign head = {snap_prefix[0], snap_prefix[1], snap_prefix[2], snap_prefix[3]};
   assign n2 = snap_count >= CNT_W'(2);
   assign n3 = snap_count >= CNT_W'(3);
   assign n4 = snap_count >= CNT_W'(4);

   // zeros > floor(n*p/100) is the same as 100*zeros > n*p
   assign null_lim    = PW'(snap_count) * PW'(null_pct);
   assign ctrl_lim    = PW'(snap_count) * PW'(nonprint_pct);
   assign zero_scaled = PW'(snap_zeros) * PW'(CENT);
   assign ctrl_scaled = PW'(snap_ctrls) * PW'(CENT);

   always_comb begin
      if (snap_count == '0)                                          verdict = V_EMPTY;
      else if (n2 && head[31:16] == SIG_GZIP)                        verdict = V_GZIP;
      else if (n4 && (head == SIG_ZIP_A || head == SIG_ZIP_B))       verdict = V_ZIP;
      else if (n4 && head == SIG_PNG)                                verdict = V_PNG;
      else if (n3 && head[31:8] == SIG_JPEG)                         verdict = V_JPEG;
      else if (n4 && head == SIG_GIF)                                verdict = V_GIF;
      else if (n4 && head == SIG_PDF)                                verdict = V_PDF;
      else if (n4 && head == SIG_ELF)                                verdict = V_ELF;
      else if (n2 && head[31:16] == SIG_MZ)                          verdict = V_MZ;
      else if (n4 && head == SIG_MACHO)                              verdict = V_MACHO;
      else if (n4 && (head == SIG_WOFF_A || head == SIG_WOFF_B))     verdict = V_WOFF;
      else if (zero_scaled > null_lim)                               verdict = V_NULLS;
      else if (ctrl_scaled > ctrl_lim)                               verdict = V_CONTROLS;
      else                                                           verdict = V_TEXT;
   end

   assign len_w  = WIDE_W'(snap_count);
   assign zero_w = WIDE_W'(snap_zeros);
   assign ctrl_w = WIDE_W'(snap_ctrls);

   always_comb begin
      rsp_in.binary_flag   = (verdict != V_TEXT) && (verdict != V_EMPTY);
      rsp_in.verdict       = verdict;
      rsp_in.sample_length = len_w[FIELD_W-1:0];
      rsp_in.zero_total    = zero_w[FIELD_W-1:0];
      rsp_in.control_total = ctrl_w[FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_v_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/binary_content_sniffer.sv
// ----------------------------------------------------------------------------
// binary_content_sniffer
// Streams file content a word at a time and gives one binary/text verdict.
// ----------------------------------------------------------------------------
// Content enters as one byte per word on req_, the final word marked by
// last. A word is taken every cycle, sustained: counting is one increment
// per word and the verdict logic is a single stage, so the only thing that
// holds req_ready low is a full pipeline behind a stalled rsp_ready. The
// verdict for a content block goes from the input register to the snapshot
// and then to the result register, which drives rsp_. Only the first
// SAMPLE_MAX bytes are counted; magic signatures win over the zero-byte
// and control-byte thresholds, which are programmed as percent values
// through the csr_ port (index 0 zero bytes, 1 control bytes).
// The csr_ port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module binary_content_sniffer #(
   parameter int SAMPLE_MAX = bcs_pkg::SAMPLE_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bcs_pkg::bcs_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bcs_pkg::bcs_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcs_pkg::PCT_W-1:0]     csr_wdata
);
   import bcs_pkg::*;

   // counters must hold SAMPLE_MAX itself
   localparam int CNT_W = $clog2(SAMPLE_MAX + 1);

   logic [PCT_W-1:0]  null_pct_ff, nonprint_pct_ff;
   logic              snap_valid, snap_ready;
   logic [3:0][7:0]   snap_prefix;
   logic [CNT_W-1:0]  snap_count, snap_zeros, snap_ctrls;

   // threshold registers, written in place
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_pct_ff     <= NULL_PCT_RST;
         nonprint_pct_ff <= NONPRINT_PCT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NULL_PCT:     null_pct_ff     <= csr_wdata;
            CSR_NONPRINT_PCT: nonprint_pct_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // counting side: holds the first four bytes and the three counts, and
   // hands a snapshot over on the last word while clearing for the next file
   bcs_accum #(
      .SAMPLE_MAX (SAMPLE_MAX),
      .CNT_W      (CNT_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_prefix (snap_prefix),
      .snap_count  (snap_count),
      .snap_zeros  (snap_zeros),
      .snap_ctrls  (snap_ctrls)
   );

   // verdict side: signature priority chain, then the threshold tests
   bcs_judge #(
      .CNT_W (CNT_W)
   ) u_judge (
      .clock        (clock),
      .reset        (reset),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap_prefix  (snap_prefix),
      .snap_count   (snap_count),
      .snap_zeros   (snap_zeros),
      .snap_ctrls   (snap_ctrls),
      .null_pct     (null_pct_ff),
      .nonprint_pct (nonprint_pct_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

>>> rtl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks on the sniffer's result channel.
// ----------------------------------------------------------------------------
module bcs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bcs_pkg::bcs_rsp_type rsp_data
);
   import bcs_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // binary flag follows the verdict
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.binary_flag ==
                    (rsp_data.verdict != V_TEXT && rsp_data.verdict != V_EMPTY))
      else $error("binary flag disagrees with verdict");

   // empty content carries no counts
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict == V_EMPTY |->
         rsp_data.sample_length == '0 && rsp_data.zero_total == '0 &&
         rsp_data.control_total == '0)
      else $error("empty verdict with non-zero counts");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid just after reset");

endmodule

bind binary_content_sniffer bcs_checker u_bcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/verdict_tracker_pkg.sv
// ----------------------------------------------------------------------------
// verdict_tracker_pkg
// Verdict predictor and result check for the binary content sniffer bench.
// ----------------------------------------------------------------------------
// Each accepted request word goes into a private copy of the sniffer's
// counters. A word with last set closes the content and queues the verdict
// due for it. Each result taken from the block is checked against the
// oldest verdict in that queue.
// ----------------------------------------------------------------------------
package verdict_tracker_pkg;

   import bcs_pkg::*;

   class verdict_tracker;

      logic [PCT_W-1:0] null_pct;
      logic [PCT_W-1:0] ctrl_pct;

      logic [7:0]  head [4];
      int unsigned seen;
      int unsigned zeros;
      int unsigned ctrls;

      bcs_rsp_type verdicts_due [$];
      int unsigned mismatch_count;

      function new();
         null_pct = NULL_PCT_RST;
         ctrl_pct = NONPRINT_PCT_RST;
         mismatch_count = 0;
         clear_content();
      endfunction

      function void clear_content();
         foreach (head[i]) head[i] = 8'h00;
         seen  = 0;
         zeros = 0;
         ctrls = 0;
      endfunction

      function void set_pct(logic [CSR_IDX_W-1:0] idx, logic [PCT_W-1:0] val);
         case (idx)
            CSR_NULL_PCT:     null_pct = val;
            CSR_NONPRINT_PCT: ctrl_pct = val;
            default: ;
         endcase
      endfunction

      // signatures first, in fixed order, each gated on enough bytes
      function logic [3:0] classify();
         logic [31:0] lead;
         lead = {head[0], head[1], head[2], head[3]};
         if (seen == 0) return V_EMPTY;
         if (seen >= 2 && lead[31:16] == SIG_GZIP) return V_GZIP;
         if (seen >= 4 && (lead == SIG_ZIP_A || lead == SIG_ZIP_B)) return V_ZIP;
         if (seen >= 4 && lead == SIG_PNG) return V_PNG;
         if (seen >= 3 && lead[31:8] == SIG_JPEG) return V_JPEG;
         if (seen >= 4 && lead == SIG_GIF) return V_GIF;
         if (seen >= 4 && lead == SIG_PDF) return V_PDF;
         if (seen >= 4 && lead == SIG_ELF) return V_ELF;
         if (seen >= 2 && lead[31:16] == SIG_MZ) return V_MZ;
         if (seen >= 4 && lead == SIG_MACHO) return V_MACHO;
         if (seen >= 4 && (lead == SIG_WOFF_A || lead == SIG_WOFF_B)) return V_WOFF;
         if (zeros > (seen * null_pct) / CENT) return V_NULLS;
         if (ctrls > (seen * ctrl_pct) / CENT) return V_CONTROLS;
         return V_TEXT;
      endfunction

      function void take_word(bcs_req_type w);
         bcs_rsp_type due;
         logic [3:0]  v;
         if (w.has_byte && seen < SAMPLE_MAX_DEF) begin
            if (seen < 4) head[seen] = w.data_byte;
            seen++;
            if (w.data_byte == BYTE_NUL) zeros++;
            if (w.data_byte < CTRL_LIMIT && w.data_byte != BYTE_TAB &&
                w.data_byte != BYTE_LF && w.data_byte != BYTE_CR) ctrls++;
         end
         if (w.last) begin
            v = classify();
            due.binary_flag   = (v != V_TEXT && v != V_EMPTY);
            due.verdict       = v;
            due.sample_length = FIELD_W'(seen);
            due.zero_total    = FIELD_W'(zeros);
            due.control_total = FIELD_W'(ctrls);
            verdicts_due.push_back(due);
            clear_content();
         end
      endfunction

      function void field_check(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      function void match_verdict(bcs_rsp_type got);
         bcs_rsp_type want;
         if (verdicts_due.size() == 0) begin
            $error("result with no verdict outstanding: %p", got);
            mismatch_count++;
            return;
         end
         want = verdicts_due.pop_front();
         field_check("binary_flag", FIELD_W'(want.binary_flag), FIELD_W'(got.binary_flag));
         field_check("verdict", FIELD_W'(want.verdict), FIELD_W'(got.verdict));
         field_check("sample_length", want.sample_length, got.sample_length);
         field_check("zero_total", want.zero_total, got.zero_total);
         field_check("control_total", want.control_total, got.control_total);
      endfunction

      function int unsigned outstanding();
         return verdicts_due.size();
      endfunction

   endclass

endpackage

>>> tb/binary_content_sniffer_tb.sv
// ----------------------------------------------------------------------------
// binary_content_sniffer_tb
// Self-checking bench for the binary content sniffer.
// ----------------------------------------------------------------------------
// A short hand-written opening covers empty content, empty end markers,
// short signatures, whitespace and the byte extremes. Random files follow:
// mostly short ones led by real or slightly broken magic numbers, or with a
// tuned mix of zero, control and printable bytes, plus two files that run
// past the sample cap. The thresholds are reprogrammed between segments,
// the extremes among them, and both handshakes are throttled in three
// phases. Every verdict is predicted and checked field by field.
// ----------------------------------------------------------------------------
module binary_content_sniffer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import bcs_pkg::*;
   import verdict_tracker_pkg::*;

   localparam int     CLK_PERIOD   = 20;
   localparam int     SETTLE       = 8;          // result trails last through the snapshot and result registers
   localparam int     SEG_WORDS    = 130;        // counted words per config segment
   localparam longint RUN_LIMIT_NS = 20_000_000; // far above any clean run

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   bcs_req_type          req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   bcs_rsp_type          rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NULL_PCT;
   logic [PCT_W-1:0]     csr_wdata = '0;

   verdict_tracker tracker;

   // throttle, in percent of cycles spent idle
   int unsigned valid_idle_pct = 0;
   int unsigned ready_idle_pct = 0;

   // words that count towards the budget: in-sample bytes and end words
   int unsigned counted_words = 0;
   int unsigned file_pos      = 0;
   int unsigned file_total    = 0;

   binary_content_sniffer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Result side: ready is redrawn every falling edge, results taken on the
   // rising edge are checked there.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.match_verdict(rsp_data);
   end

   // Present one request word, with random idle cycles ahead of it. Valid
   // is left high after the handshake; the next word, an idle cycle or a
   // drain lowers or reuses it at the following falling edge.
   task automatic push_word(input logic [7:0] b, input logic has, input logic fin);
      bcs_req_type w;
      w.data_byte = b;
      w.has_byte  = has;
      w.last      = fin;
      @(negedge clock);
      while ($urandom_range(0, 99) < valid_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      tracker.take_word(w);
      if (fin || (has && file_pos < SAMPLE_MAX_DEF)) counted_words++;
      if (fin) file_pos = 0;
      else if (has) file_pos++;
   endtask

   // Hold off the sender until every verdict has come back, then give any
   // word still in the pipe time to land.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_pct(input logic [CSR_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_pct(idx, val);
   endtask

   // only ever called with the block drained
   task automatic configure(input logic [PCT_W-1:0] null_pct, input logic [PCT_W-1:0] ctrl_pct);
      write_pct(CSR_NULL_PCT, null_pct);
      write_pct(CSR_NONPRINT_PCT, ctrl_pct);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One file of n_bytes content bytes. Style is drawn per file:
   //   0 magic number (sometimes with one bit flipped) then a mixed body
   //   1 mixed zero / control / printable bytes at random densities
   //   2 plain text with whitespace
   //   3 raw random bytes
   // Empty words are sprinkled in, and the end is either the last byte or
   // an empty end marker.
   task automatic send_file(input int unsigned n_bytes);
      logic [31:0] sig;
      logic [7:0]  b;
      int unsigned sig_len, mode, pz, pc, r, flip;
      bit          end_empty;
      sig     = SIG_ZIP_A;
      sig_len = 4;
      mode    = $urandom_range(0, 3);
      case ($urandom_range(0, 11))
         0:  begin sig = {SIG_GZIP, 16'h0000}; sig_len = 2; end
         1:  sig = SIG_ZIP_A;
         2:  sig = SIG_ZIP_B;
         3:  sig = SIG_PNG;
         4:  begin sig = {SIG_JPEG, 8'h00}; sig_len = 3; end
         5:  sig = SIG_GIF;
         6:  sig = SIG_PDF;
         7:  sig = SIG_ELF;
         8:  begin sig = {SIG_MZ, 16'h0000}; sig_len = 2; end
         9:  sig = SIG_MACHO;
         10: sig = SIG_WOFF_A;
         default: sig = SIG_WOFF_B;
      endcase
      if ($urandom_range(0, 4) == 0) begin
         flip = $urandom_range(0, 8 * sig_len - 1);
         sig[31 - flip] = ~sig[31 - flip];
      end
      // thin densities half the time so the default 1 % null limit is hit
      // near its edge, heavy ones otherwise
      pz = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 100);
      pc = $urandom_range(0, 100 - pz);
      if (mode == 2) begin
         pz = 0;
         pc = 0;
      end
      end_empty = (n_bytes == 0) || ($urandom_range(0, 3) == 0);

      for (int unsigned i = 0; i < n_bytes; i++) begin
         if ($urandom_range(0, 9) == 0) push_word(8'($urandom), 1'b0, 1'b0);
         r = $urandom_range(0, 99);
         if (mode == 0 && i < sig_len) b = sig[31 - 8 * i -: 8];
         else if (mode == 3) b = 8'($urandom);
         else if (r < pz) b = BYTE_NUL;
         else if (r < pz + pc) b = 8'($urandom_range(1, 31));
         else if (r < pz + pc + 8) begin
            case ($urandom_range(0, 2))
               0:       b = BYTE_TAB;
               1:       b = BYTE_LF;
               default: b = BYTE_CR;
            endcase
         end
         else if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(128, 255));
         else b = 8'($urandom_range(32, 126));
         push_word(b, 1'b1, (i == n_bytes - 1) && !end_empty);
      end
      if (end_empty) push_word(8'($urandom), 1'b0, 1'b1);
      file_total++;
   endtask

   // Opening words, run with the reset thresholds (1 % and 30 %):
   // empty content, empty words before an empty end, two-byte gzip,
   // three-byte JPEG, PNG cut short, whitespace and the edges of the
   // control range, a zero byte beside 0xFF, a lone control byte, MZ.
   localparam bcs_req_type OPENING [23] = '{
      '{8'h00, 1'b0, 1'b1},
      '{8'hFF, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'h1F, 1'b1, 1'b0}, '{8'h8B, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b0}, '{8'hD8, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b1},
      '{8'h89, 1'b1, 1'b0}, '{8'h50, 1'b1, 1'b0}, '{8'h4E, 1'b1, 1'b1},
      '{BYTE_TAB, 1'b1, 1'b0}, '{BYTE_LF, 1'b1, 1'b0}, '{BYTE_CR, 1'b1, 1'b0},
      '{8'h20, 1'b1, 1'b0}, '{8'h7F, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'h1F, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'h4D, 1'b1, 1'b0}, '{8'h5A, 1'b1, 1'b1}
   };

   initial begin
      int unsigned seg_start, seg_files, seg;
      logic [PCT_W-1:0] null_set [6];
      logic [PCT_W-1:0] ctrl_set [6];

      tracker = new();
      // reset values first, then both extremes, past 100, random, a mix
      null_set = '{NULL_PCT_RST, 7'd0, 7'd100, 7'd127, 7'd0, 7'd3};
      ctrl_set = '{NONPRINT_PCT_RST, 7'd0, 7'd100, 7'd127, 7'd0, 7'd50};
      null_set[4] = 7'($urandom_range(0, 127));
      ctrl_set[4] = 7'($urandom_range(0, 127));

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING[i]) begin
         push_word(OPENING[i].data_byte, OPENING[i].has_byte, OPENING[i].last);
      end
      drain();

      // three throttle phases, two threshold settings in each
      seg = 0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0:       begin valid_idle_pct = 7;  ready_idle_pct = 77; end
            1:       begin valid_idle_pct = 77; ready_idle_pct = 7;  end
            default: begin valid_idle_pct = 0;  ready_idle_pct = 0;  end
         endcase
         for (int k = 0; k < 2; k++) begin
            configure(null_set[seg], ctrl_set[seg]);
            seg_start = counted_words;
            seg_files = 0;
            while (counted_words - seg_start < SEG_WORDS || seg_files < 8) begin
               // two files overrun the sample cap, the rest stay short
               if (file_total == 30) send_file($urandom_range(520, 530));
               else if (file_total == 60) send_file($urandom_range(513, 530));
               else send_file($urandom_range(0, 24));
               seg_files++;
               if ($urandom_range(0, 29) == 0) drain();
            end
            drain();
            seg++;
         end
      end

      if (tracker.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
rtl/bcs_pkg.sv
rtl/bcs_accum.sv
rtl/bcs_judge.sv
rtl/binary_content_sniffer.sv
rtl/bcs_checker.sv
tb/verdict_tracker_pkg.sv
tb/binary_content_sniffer_tb.sv
